[rtl/tap_tempo_ratio_rhythm_generator_defines.svh]
// Assertion macros shared by the tap tempo rhythm generator RTL.
`ifndef TAP_TEMPO_RATIO_RHYTHM_GENERATOR_DEFINES_SVH
`define TAP_TEMPO_RATIO_RHYTHM_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTR_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/ttr_pkg.sv]
// Package of the tap tempo rhythm generator: constants, codes and control structs.
package ttr_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int RATIO_ENTRIES   = 3;
  localparam int RATIO_IDX_MAX   = RATIO_ENTRIES - 1;
  localparam int RESYNC_COUNT    = 16000;
  localparam int INITIAL_PERIOD  = 320;
  localparam int INITIAL_PULSE   = 16;
  localparam int SPAN_NUMERATOR  = RATIO_ENTRIES << 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int PULSE_W    = 8;
  localparam int RATIO_W    = 4;
  localparam int SENSOR_W   = 8;
  localparam int DIVISOR_W  = 8;
  localparam int IDX_W      = 2;
  localparam int QSPAN_W    = 10;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;

  // Register reset values
  localparam logic [PULSE_W-1:0] PULSE_BASE_RST = 8'd16;
  localparam logic [RATIO_W-1:0] MUL_0_RST = 4'd1;
  localparam logic [RATIO_W-1:0] MUL_1_RST = 4'd2;
  localparam logic [RATIO_W-1:0] MUL_2_RST = 4'd3;
  localparam logic [RATIO_W-1:0] DIV_0_RST = 4'd3;
  localparam logic [RATIO_W-1:0] DIV_1_RST = 4'd3;
  localparam logic [RATIO_W-1:0] DIV_2_RST = 4'd4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_BASE = 3'd0,
    CFG_MUL_0      = 3'd1,
    CFG_MUL_1      = 3'd2,
    CFG_MUL_2      = 3'd3,
    CFG_DIV_0      = 3'd4,
    CFG_DIV_1      = 3'd5,
    CFG_DIV_2      = 3'd6
  } cfg_index_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic finish;
  } ttr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_slow;
    logic recalc;
    logic span_nz;
    logic div_done;
    logic out_free;
  } ttr_status_t;

endpackage

[rtl/ttr_div.sv]
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
module ttr_div #(
  parameter int DW = ttr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [DW-1:0]                  dividend,
  input  logic [ttr_pkg::DIVISOR_W-1:0]  divisor,
  output logic [DW-1:0]                  quotient,
  output logic                           done
);

  localparam int CW = $clog2(DW + 1);
  localparam int RW = ttr_pkg::DIVISOR_W;

  logic [DW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] dvsr_r, dvsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;

  // one shift-subtract step
  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign ge    = trial >= {1'b0, dvsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[rtl/ttr_datapath.sv]
// Datapath: rhythm state, configuration registers, shared divider, result register.
module ttr_datapath #(
  parameter int COUNT_WIDTH = ttr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ttr_pkg::ttr_cmd_t               cmd,
  output ttr_pkg::ttr_status_t            st,
  input  logic [ttr_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic [ttr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            cfg_we,
  input  logic [ttr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ttr_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int W   = COUNT_WIDTH;
  localparam int PW  = ttr_pkg::PULSE_W;
  localparam int RTW = ttr_pkg::RATIO_W;
  localparam int SW  = ttr_pkg::SENSOR_W;
  localparam int QW  = ttr_pkg::QSPAN_W;
  localparam int IW  = ttr_pkg::IDX_W;
  localparam int MAXC = (2 ** W) - 1;
  localparam logic [W-1:0] RESYNC =
    W'((ttr_pkg::RESYNC_COUNT < MAXC) ? ttr_pkg::RESYNC_COUNT : MAXC);
  localparam logic [W-1:0] INIT_PERIOD = W'(ttr_pkg::INITIAL_PERIOD);
  localparam logic [PW-1:0] INIT_PULSE = PW'(ttr_pkg::INITIAL_PULSE);
  localparam logic [IW-1:0] IDX_MAX = IW'(ttr_pkg::RATIO_IDX_MAX);

  // rhythm state
  logic [W-1:0]   beat_r, beat_nxt;
  logic [W-1:0]   main_r, main_nxt;
  logic [W-1:0]   sec_r, sec_nxt;
  logic [W-1:0]   sper_r, sper_nxt;
  logic [W-1:0]   tap_r, tap_nxt;
  logic [PW-1:0]  pleft_r, pleft_nxt;
  logic           pact_r, pact_nxt;
  logic           recalc_r, recalc_nxt;
  logic           son_r, son_nxt;
  logic [RTW-1:0] cmul_r, cmul_nxt;
  logic [RTW-1:0] cdiv_r, cdiv_nxt;
  logic [SW-1:0]  low_r, low_nxt;
  logic [SW-1:0]  high_r, high_nxt;
  // latched beat
  logic           slow_r;
  logic [SW-1:0]  smp_r;
  // configuration
  logic [PW-1:0]  base_r;
  logic [RTW-1:0] rmul_r [ttr_pkg::RATIO_ENTRIES];
  logic [RTW-1:0] rdiv_r [ttr_pkg::RATIO_ENTRIES];
  // result register
  logic           out_valid_r, out_valid_nxt;
  logic           motor_r;
  logic           sen_r;

  logic           key_release;
  logic           key_long;
  logic [SW-1:0]  sample;
  logic [RTW-1:0] cdiv_nz;
  logic [SW-1:0]  span;
  logic [SW-1:0]  offs;
  logic [W-1:0]   div_dividend;
  logic [ttr_pkg::DIVISOR_W-1:0] div_divisor;
  logic [W-1:0]   quotient;
  logic           div_done;
  logic [W+RTW-1:0] period_prod;
  logic [QW+SW-1:0] idx_prod;
  logic [QW-1:0]    idx_raw;
  logic [IW-1:0]    idx;

  assign key_release = in_tdata[0];
  assign key_long    = in_tdata[1];
  assign sample      = in_tdata[SW+1:2];

  assign cdiv_nz = (cdiv_r == '0) ? RTW'(1) : cdiv_r;
  assign span    = high_r - low_r;
  assign offs    = smp_r - low_r;

  // divider operands: sensor scale on a slow beat, period on a fast one
  assign div_dividend = slow_r ? W'(ttr_pkg::SPAN_NUMERATOR) : beat_r;
  assign div_divisor  = slow_r ? span : {{(ttr_pkg::DIVISOR_W-RTW){1'b0}}, cdiv_nz};

  ttr_div #(
    .DW(W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign period_prod = (W+RTW)'(quotient) * (W+RTW)'(cmul_r);
  assign idx_prod    = (QW+SW)'(quotient[QW-1:0]) * (QW+SW)'(offs);
  assign idx_raw     = idx_prod[QW+SW-1:SW];

  // ratio entry, clamped; a flat sensor range picks entry zero
  always_comb begin
    if (high_r <= low_r) begin
      idx = '0;
    end else if (idx_raw > QW'(IDX_MAX)) begin
      idx = IDX_MAX;
    end else begin
      idx = idx_raw[IW-1:0];
    end
  end

  // state update
  always_comb begin
    logic [W-1:0]  sp;
    logic [W-1:0]  mc;
    logic [W-1:0]  sc;
    logic          pa;
    logic [PW-1:0] pl;
    beat_nxt   = beat_r;
    main_nxt   = main_r;
    sec_nxt    = sec_r;
    sper_nxt   = sper_r;
    tap_nxt    = tap_r;
    pleft_nxt  = pleft_r;
    pact_nxt   = pact_r;
    recalc_nxt = recalc_r;
    son_nxt    = son_r;
    cmul_nxt   = cmul_r;
    cdiv_nxt   = cdiv_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    sp = recalc_r ? period_prod[W-1:0] : sper_r;
    mc = main_r + 1'b1;
    sc = sec_r + 1'b1;
    pa = pact_r;
    pl = pleft_r;

    if (cmd.accept && in_tuser[0]) begin
      // slow beat: keys and sensor range
      if (key_release) begin
        beat_nxt = tap_r;
        tap_nxt  = '0;
        main_nxt = RESYNC;
      end
      if (key_long) begin
        son_nxt = !son_r;
      end
      if (sample < low_r) begin
        low_nxt = sample;
      end
      if (sample > high_r) begin
        high_nxt = sample;
      end
      recalc_nxt = 1'b1;
    end else if (cmd.finish && slow_r) begin
      unique case (idx)
        2'd0: begin
          cmul_nxt = rmul_r[0];
          cdiv_nxt = rdiv_r[0];
        end
        2'd1: begin
          cmul_nxt = rmul_r[1];
          cdiv_nxt = rdiv_r[1];
        end
        default: begin
          cmul_nxt = rmul_r[2];
          cdiv_nxt = rdiv_r[2];
        end
      endcase
    end else if (cmd.finish) begin
      // fast beat: count, fire, shape the pulse
      if (sc >= sp) begin
        sc = '0;
        if (son_r) begin
          pa = 1'b1;
        end
      end
      if (mc >= beat_r) begin
        mc = '0;
        pa = 1'b1;
      end
      if (pa) begin
        pl = pl - 1'b1;
        if (pl == '0) begin
          pa = 1'b0;
          pl = base_r + sp[PW+3:4];
        end
      end
      main_nxt   = mc;
      sec_nxt    = sc;
      tap_nxt    = tap_r + 1'b1;
      sper_nxt   = sp;
      recalc_nxt = 1'b0;
      pact_nxt   = pa;
      pleft_nxt  = pl;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slow_r <= in_tuser[0];
      smp_r  <= sample;
    end
    if (cmd.finish) begin
      motor_r <= pact_nxt;
      sen_r   <= son_r;
    end
    if (!rst_n) begin
      beat_r      <= INIT_PERIOD;
      main_r      <= '0;
      sec_r       <= '0;
      sper_r      <= INIT_PERIOD;
      tap_r       <= '0;
      pleft_r     <= INIT_PULSE;
      pact_r      <= 1'b0;
      recalc_r    <= 1'b0;
      son_r       <= 1'b1;
      cmul_r      <= RTW'(1);
      cdiv_r      <= RTW'(1);
      low_r       <= '1;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      main_r      <= main_nxt;
      sec_r       <= sec_nxt;
      sper_r      <= sper_nxt;
      tap_r       <= tap_nxt;
      pleft_r     <= pleft_nxt;
      pact_r      <= pact_nxt;
      recalc_r    <= recalc_nxt;
      son_r       <= son_nxt;
      cmul_r      <= cmul_nxt;
      cdiv_r      <= cdiv_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= ttr_pkg::PULSE_BASE_RST;
      rmul_r[0] <= ttr_pkg::MUL_0_RST;
      rmul_r[1] <= ttr_pkg::MUL_1_RST;
      rmul_r[2] <= ttr_pkg::MUL_2_RST;
      rdiv_r[0] <= ttr_pkg::DIV_0_RST;
      rdiv_r[1] <= ttr_pkg::DIV_1_RST;
      rdiv_r[2] <= ttr_pkg::DIV_2_RST;
    end else if (cfg_we) begin
      unique case (ttr_pkg::cfg_index_t'(cfg_index))
        ttr_pkg::CFG_PULSE_BASE: base_r    <= cfg_data;
        ttr_pkg::CFG_MUL_0:      rmul_r[0] <= cfg_data[RTW-1:0];
        ttr_pkg::CFG_MUL_1:      rmul_r[1] <= cfg_data[RTW-1:0];
        ttr_pkg::CFG_MUL_2:      rmul_r[2] <= cfg_data[RTW-1:0];
        ttr_pkg::CFG_DIV_0:      rdiv_r[0] <= cfg_data[RTW-1:0];
        ttr_pkg::CFG_DIV_1:      rdiv_r[1] <= cfg_data[RTW-1:0];
        ttr_pkg::CFG_DIV_2:      rdiv_r[2] <= cfg_data[RTW-1:0];
        default: ;
      endcase
    end
  end

  assign st.is_slow  = slow_r;
  assign st.recalc   = recalc_r;
  assign st.span_nz  = high_r > low_r;
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ttr_pkg::OUT_DATA_W-2){1'b0}}, sen_r, motor_r};

endmodule

[rtl/ttr_ctrl.sv]
// Controller: sequences accept, divide and result write for one beat at a time.
module ttr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  ttr_pkg::ttr_status_t  st,
  output ttr_pkg::ttr_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && ready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      // divide only when a ratio or a new period is needed
      S_PREP: begin
        if (st.is_slow ? st.span_nz : st.recalc) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = S_FIN;
        end
      end
      // hold until the result register is free
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = ready_r;

endmodule

[rtl/tap_tempo_ratio_rhythm_generator.sv]
// Two-rhythm motor pulse generator with tap tempo: input, result and register ports.
//
// Input beats: in_tuser[0] selects a fast tick (0) or a slow control tick (1);
// in_tdata carries key_release, key_long and the 8-bit sensor sample.
// Every input beat yields one result beat: motor_on and second_enabled.
// Registers are written through cfg_we/cfg_index/cfg_data while idle.
//
// Sequence: a fast tick with no pending recalculation goes from accept through
// the prepare and finish states back to idle, where the next beat can be accepted.
// A fast tick after a slow tick, or a slow tick with a non-zero sensor span,
// also runs the shared radix-2 divider in a divide state between the two.
// The result register is written in the finish state once it is free and
// shows the result on the following cycle.
//
// Reset (rst_n low, synchronous) restores the rhythm state, configuration
// registers and handshake; the block is ready in the cycle after rst_n rises.
// While out_tready is low a finished result stays in the output register; one
// further beat is accepted and computed, then held until the register frees.
module tap_tempo_ratio_rhythm_generator #(
  parameter int COUNT_WIDTH = ttr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] key_release, [1] key_long, [9:2] sensor_sample, rest zero
  input  logic [ttr_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] action
  input  logic [ttr_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] motor_on, [1] second_enabled, rest zero
  output logic [ttr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [ttr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `include "tap_tempo_ratio_rhythm_generator_defines.svh"

  ttr_pkg::ttr_cmd_t    cmd;
  ttr_pkg::ttr_status_t st;

  ttr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ttr_datapath #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // busy once a beat is taken
  `TTR_ASSERT_NEXT(a_busy_after_accept, cmd.accept, !in_tready, "ready after accept")
  // a result is only written into a free register
  `TTR_ASSERT_NOW(a_finish_free, cmd.finish, st.out_free, "result register overwritten")
  // a written result is offered next cycle
  `TTR_ASSERT_NEXT(a_finish_valid, cmd.finish, out_tvalid, "result not presented")

endmodule

[sim/tap_tempo_ratio_rhythm_generator_tb.sv]
// Self-checking testbench of the tap tempo ratio rhythm generator.

// Holds a running copy of the rhythm state and the motor/second-rhythm flags it should output.
class rhythm_scoreboard;
  localparam int CW = ttr_pkg::COUNT_WIDTH_DEF;
  localparam int COUNT_MAX = (1 << CW) - 1;
  localparam int MSG_CAP = 20;

  typedef struct packed {
    bit second_enabled;
    bit motor_on;
  } pulse_flags_t;

  // register copies
  bit [7:0] pulse_base;
  bit [3:0] ratio_mul [3];
  bit [3:0] ratio_div [3];

  // rhythm state
  bit [CW-1:0] beat_period, main_count, second_count, second_period, tap_measure;
  bit [7:0] pulse_left;
  bit pulse_active, recalc_pending, second_on;
  bit [3:0] cur_mul, cur_div;
  bit [7:0] sensor_low, sensor_high;

  pulse_flags_t predicted_flags[$];
  int errors;
  int result_idx;

  function new();
    pulse_base = ttr_pkg::PULSE_BASE_RST;
    ratio_mul[0] = ttr_pkg::MUL_0_RST;
    ratio_mul[1] = ttr_pkg::MUL_1_RST;
    ratio_mul[2] = ttr_pkg::MUL_2_RST;
    ratio_div[0] = ttr_pkg::DIV_0_RST;
    ratio_div[1] = ttr_pkg::DIV_1_RST;
    ratio_div[2] = ttr_pkg::DIV_2_RST;
    beat_period = CW'(ttr_pkg::INITIAL_PERIOD);
    second_period = CW'(ttr_pkg::INITIAL_PERIOD);
    main_count = '0;
    second_count = '0;
    tap_measure = '0;
    pulse_left = 8'(ttr_pkg::INITIAL_PULSE);
    pulse_active = 1'b0;
    recalc_pending = 1'b0;
    second_on = 1'b1;
    cur_mul = 4'd1;
    cur_div = 4'd1;
    sensor_low = 8'hFF;
    sensor_high = 8'h00;
    errors = 0;
    result_idx = 0;
  endfunction

  // Register write; unknown indexes fall through
  function void write_reg(bit [ttr_pkg::CFG_IDX_W-1:0] index, bit [7:0] value);
    case (index)
      ttr_pkg::CFG_PULSE_BASE: pulse_base = value;
      ttr_pkg::CFG_MUL_0:      ratio_mul[0] = value[3:0];
      ttr_pkg::CFG_MUL_1:      ratio_mul[1] = value[3:0];
      ttr_pkg::CFG_MUL_2:      ratio_mul[2] = value[3:0];
      ttr_pkg::CFG_DIV_0:      ratio_div[0] = value[3:0];
      ttr_pkg::CFG_DIV_1:      ratio_div[1] = value[3:0];
      ttr_pkg::CFG_DIV_2:      ratio_div[2] = value[3:0];
      default: ;
    endcase
  endfunction

  // Advance the rhythm by one accepted input beat and queue the flags it leaves
  function void note_beat(bit slow, bit tap, bit hold, bit [7:0] sample);
    bit [3:0] divisor;
    bit [31:0] product;
    int unsigned span, offset, scaled;
    bit [1:0] entry;
    pulse_flags_t flags;
    if (!slow) begin
      main_count++;
      second_count++;
      tap_measure++;
      if (recalc_pending) begin
        divisor = (cur_div == 0) ? 4'd1 : cur_div;
        recalc_pending = 1'b0;
        product = (beat_period / divisor) * cur_mul;
        second_period = product[CW-1:0];
      end
      if (second_count >= second_period) begin
        second_count = '0;
        if (second_on) pulse_active = 1'b1;
      end
      if (main_count >= beat_period) begin
        main_count = '0;
        pulse_active = 1'b1;
      end
      if (pulse_active) begin
        pulse_left = pulse_left - 8'd1;
        if (pulse_left == 0) begin
          pulse_active = 1'b0;
          pulse_left = 8'(pulse_base + (second_period >> 4));
        end
      end
    end else begin
      // tap: measured count becomes the beat, main counter resyncs
      if (tap) begin
        beat_period = tap_measure;
        tap_measure = '0;
        main_count = CW'((ttr_pkg::RESYNC_COUNT > COUNT_MAX) ? COUNT_MAX
                                                             : ttr_pkg::RESYNC_COUNT);
        recalc_pending = 1'b1;
      end
      if (hold) second_on = !second_on;
      // self-calibrating sensor picks the ratio entry
      if (sample < sensor_low) sensor_low = sample;
      if (sample > sensor_high) sensor_high = sample;
      entry = 2'd0;
      if (sensor_high > sensor_low) begin
        span = 32'(sensor_high - sensor_low);
        offset = 32'(sample - sensor_low);
        scaled = ((ttr_pkg::SPAN_NUMERATOR / span) * offset) >> 8;
        entry = (scaled > ttr_pkg::RATIO_IDX_MAX) ? 2'(ttr_pkg::RATIO_IDX_MAX) : 2'(scaled);
      end
      cur_mul = ratio_mul[entry];
      cur_div = ratio_div[entry];
      recalc_pending = 1'b1;
    end
    flags.motor_on = pulse_active;
    flags.second_enabled = second_on;
    predicted_flags.push_back(flags);
  endfunction

  function int pending();
    return predicted_flags.size();
  endfunction

  task report(string what);
    errors++;
    if (errors <= MSG_CAP) $display("mismatch at result %0d: %s", result_idx, what);
  endtask

  // Compare one result beat with the oldest prediction
  task check_result(bit [7:0] data);
    pulse_flags_t want;
    result_idx++;
    if (predicted_flags.size() == 0) begin
      report("result beat with nothing predicted");
      return;
    end
    want = predicted_flags.pop_front();
    if (data[0] !== want.motor_on)
      report($sformatf("motor_on %0b, predicted %0b", data[0], want.motor_on));
    if (data[1] !== want.second_enabled)
      report($sformatf("second_enabled %0b, predicted %0b", data[1], want.second_enabled));
  endtask
endclass

module tap_tempo_ratio_rhythm_generator_tb;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_RUN = 500;
  localparam int CFG_IW = ttr_pkg::CFG_IDX_W;
  localparam int IN_W = ttr_pkg::IN_DATA_W;
  localparam bit TICK_FAST = 1'b0;
  localparam bit TICK_SLOW = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [ttr_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [ttr_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [ttr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ttr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tready;
  logic out_tvalid;
  logic [ttr_pkg::OUT_DATA_W-1:0] out_tdata;

  rhythm_scoreboard sb = new();
  int burst_left = 0;
  int ready_left = 0;
  int idle_cycles = 0;

  tap_tempo_ratio_rhythm_generator dut (.*);

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver: long ready stretches, stalls and short toggling runs
  always @(posedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_tready <= 1'b1;
          ready_left <= $urandom_range(40, 120);
        end
        1: begin
          out_tready <= 1'b0;
          ready_left <= $urandom_range(1, 12);
        end
        default: begin
          out_tready <= ~out_tready;
          ready_left <= $urandom_range(1, 6);
        end
      endcase
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Beat monitors and watchdog
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_beat(in_tuser[0], in_tdata[0], in_tdata[1], in_tdata[9:2]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one input beat; the sender runs in bursts with idle gaps between
  task automatic send_beat(input bit slow, input bit tap, input bit hold, input bit [7:0] sample);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= slow;
    in_tdata <= IN_W'({sample, hold, tap});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Idle the block, then write every register plus the unused index
  task automatic load_settings(input bit [7:0] base, input bit [2:0][3:0] mul,
                               input bit [2:0][3:0] div);
    bit [7:0] value;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < (1 << CFG_IW); i++) begin
      // junk in the upper nibble of ratio writes must be dropped
      case (ttr_pkg::cfg_index_t'(i))
        ttr_pkg::CFG_PULSE_BASE: value = base;
        ttr_pkg::CFG_MUL_0: value = {4'($urandom_range(0, 15)), mul[0]};
        ttr_pkg::CFG_MUL_1: value = {4'($urandom_range(0, 15)), mul[1]};
        ttr_pkg::CFG_MUL_2: value = {4'($urandom_range(0, 15)), mul[2]};
        ttr_pkg::CFG_DIV_0: value = {4'($urandom_range(0, 15)), div[0]};
        ttr_pkg::CFG_DIV_1: value = {4'($urandom_range(0, 15)), div[1]};
        ttr_pkg::CFG_DIV_2: value = {4'($urandom_range(0, 15)), div[2]};
        default:   value = 8'($urandom_range(0, 255));
      endcase
      cfg_we <= 1'b1;
      cfg_index <= CFG_IW'(i);
      cfg_data <= value;
      sb.write_reg(CFG_IW'(i), value);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_random_settings();
    bit [2:0][3:0] mul, div;
    for (int e = 0; e < ttr_pkg::RATIO_ENTRIES; e++) begin
      mul[e] = 4'($urandom_range(1, 15));
      div[e] = 4'($urandom_range(1, 15));
    end
    load_settings(8'($urandom_range(1, 255)), mul, div);
  endtask

  // Runs of fast ticks closed by a control tick, with some noise
  task automatic run_rhythms(input int count);
    int sent;
    int ticks;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0: begin
          send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          sent++;
        end
        1: begin
          // two taps with nothing between: zero beat period
          send_beat(TICK_SLOW, 1'b1, 1'b0, 8'($urandom_range(0, 255)));
          send_beat(TICK_SLOW, 1'b1, 1'b0, 8'($urandom_range(0, 255)));
          ticks = $urandom_range(2, 10);
          repeat (ticks) send_beat(TICK_FAST, 1'b0, 1'b0, 8'h00);
          sent += ticks + 2;
        end
        default: begin
          ticks = $urandom_range(4, 90);
          repeat (ticks)
            send_beat(TICK_FAST, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
          send_beat(TICK_SLOW, $urandom_range(0, 2) == 0, $urandom_range(0, 9) == 0,
                    8'($urandom_range(0, 255)));
          sent += ticks + 1;
        end
      endcase
      if ($urandom_range(0, 40) == 0) drain();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on reset settings
    // key and sensor fields on a fast tick are ignored
    send_beat(TICK_FAST, 1'b1, 1'b1, 8'hFF);
    // first reading: no sensor span, entry zero
    send_beat(TICK_SLOW, 1'b0, 1'b0, 8'd100);
    // span of one at the top reading: index clamps to the last entry
    send_beat(TICK_SLOW, 1'b0, 1'b0, 8'd101);
    send_beat(TICK_FAST, 1'b0, 1'b0, 8'h00);
    // widen the span to full scale, then a middle reading
    send_beat(TICK_SLOW, 1'b0, 1'b0, 8'h00);
    send_beat(TICK_SLOW, 1'b0, 1'b0, 8'hFF);
    send_beat(TICK_SLOW, 1'b0, 1'b0, 8'd128);
    repeat (3) send_beat(TICK_FAST, 1'b0, 1'b0, 8'h00);
    // long press turns the second rhythm off and back on
    send_beat(TICK_SLOW, 1'b0, 1'b1, 8'd64);
    send_beat(TICK_FAST, 1'b0, 1'b0, 8'h00);
    send_beat(TICK_SLOW, 1'b0, 1'b1, 8'd192);
    // back-to-back taps: beat period of zero fires on every tick
    send_beat(TICK_SLOW, 1'b1, 1'b0, 8'd32);
    send_beat(TICK_SLOW, 1'b1, 1'b0, 8'd32);
    repeat (4) send_beat(TICK_FAST, 1'b0, 1'b0, 8'h00);
    // tap after a few ticks resyncs the main counter
    send_beat(TICK_SLOW, 1'b1, 1'b0, 8'd200);
    repeat (3) send_beat(TICK_FAST, 1'b0, 1'b0, 8'h00);

    // Extreme settings
    load_settings(8'd1, {4'd7, 4'd1, 4'd15}, {4'd2, 4'd15, 4'd1});
    run_rhythms(PHASE_ITEMS);
    load_settings(8'd255, {4'd15, 4'd15, 4'd1}, {4'd1, 4'd1, 4'd15});
    run_rhythms(PHASE_ITEMS);
    // divisor of zero on entry zero is taken as one
    load_settings(8'd240, {4'd3, 4'd15, 4'd15}, {4'd7, 4'd1, 4'd0});
    run_rhythms(PHASE_ITEMS);
    repeat (3) begin
      load_random_settings();
      run_rhythms(PHASE_ITEMS);
    end

    // Long beat with the largest ratio so the pulse length wraps at 8 bits
    load_settings(8'($urandom_range(1, 255)), {4'd15, 4'd15, 4'd15}, {4'd1, 4'd1, 4'd1});
    send_beat(TICK_SLOW, 1'b1, 1'b0, 8'($urandom_range(0, 255)));
    repeat (LONG_RUN) send_beat(TICK_FAST, 1'b0, 1'b0, 8'h00);
    send_beat(TICK_SLOW, 1'b1, 1'b0, 8'($urandom_range(0, 255)));
    run_rhythms(PHASE_ITEMS);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
